// ===== src/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg
// Types, codes and literal tables for the chat line classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int NAME_LIMIT_W    = 6;
	localparam int CONTENT_LIMIT_W = 11;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 11;
	localparam int POS_W           = 4;

	localparam logic [NAME_LIMIT_W-1:0]    NAME_LIMIT_RST    = 6'd20;
	localparam logic [CONTENT_LIMIT_W-1:0] CONTENT_LIMIT_RST = 11'd1400;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [71:0] LEAD_MSG   = 72'("MSG FROM ");
	localparam logic [71:0] LEAD_ERR   = 72'("ERR FROM ");
	localparam logic [71:0] LEAD_REPLY = 72'("REPLY ");
	localparam logic [71:0] LEAD_BYE   = 72'({"BYE", 8'h0D, 8'h0A});
	localparam logic [31:0] IS_TEXT    = " IS ";
	localparam logic [23:0] WORD_NOK   = "NOK";
	localparam logic [15:0] WORD_OK    = "OK";

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NAME_LIMIT    = 2'd0,
		CFG_CONTENT_LIMIT = 2'd1
	} cfg_index_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_LIT,
		PH_NAME,
		PH_WORD,
		PH_IS,
		PH_CONTENT,
		PH_LF,
		PH_DONE,
		PH_DEAD
	} phase_t;

	typedef enum logic [2:0] {
		KIND_MSG     = 3'd0,
		KIND_ERR     = 3'd1,
		KIND_REPLY   = 3'd2,
		KIND_BYE     = 3'd3,
		KIND_UNKNOWN = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		TAG_NONE    = 2'd0,
		TAG_NAME    = 2'd1,
		TAG_CONTENT = 2'd2,
		TAG_WORD    = 2'd3
	} tag_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_line;
	} clc_in_t;

	typedef struct packed {
		logic [1:0] field_tag;
		logic       line_done;
		logic [2:0] message_kind;
		logic       reply_ok;
	} clc_out_t;

	typedef struct packed {
		logic [NAME_LIMIT_W-1:0]    name_limit;
		logic [CONTENT_LIMIT_W-1:0] content_limit;
	} clc_cfg_t;

	function automatic logic [POS_W-1:0] lead_len(input kind_t k);
		logic [POS_W-1:0] len;
		unique case (k)
			KIND_MSG, KIND_ERR: len = 4'd9;
			KIND_REPLY:         len = 4'd6;
			KIND_BYE:           len = 4'd5;
			default:            len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] lead_char(input kind_t k, input logic [POS_W-1:0] pos);
		logic [71:0]      txt;
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] idx;
		unique case (k)
			KIND_MSG:   txt = LEAD_MSG;
			KIND_ERR:   txt = LEAD_ERR;
			KIND_REPLY: txt = LEAD_REPLY;
			default:    txt = LEAD_BYE;
		endcase
		len = lead_len(k);
		idx = len - pos - 4'd1;
		if (pos >= len) begin
			return 8'h00;
		end
		return txt[idx*8 +: 8];
	endfunction

	function automatic logic [7:0] word_char(input logic ok, input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (ok) begin
			if (pos < 4'd2) c = WORD_OK[(1 - int'(pos))*8 +: 8];
		end else begin
			if (pos < 4'd3) c = WORD_NOK[(2 - int'(pos))*8 +: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] is_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 4'd4) c = IS_TEXT[(3 - int'(pos))*8 +: 8];
		return c;
	endfunction

	function automatic logic is_name_char(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || b == "-";
	endfunction

endpackage

// ===== src/chat_line_classifier.sv =====
// ----------------------------------------------------------------------------
// chat_line_classifier
// Path: input register, one parse step, result register; the result
// register and the input register hold while out_ready stalls the output.
// Throughput: one byte per cycle while out_ready does not stall the output; the parse state updates once per byte.
// Reset: parser returns to line start, limits to 20 and 1400, both stages empty.
// ----------------------------------------------------------------------------
module chat_line_classifier #(
	parameter int NAME_COUNT_BITS    = 6,
	parameter int CONTENT_COUNT_BITS = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  clc_pkg::clc_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output clc_pkg::clc_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [clc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import clc_pkg::*;

	clc_in_t  word_s1;
	logic     valid_s1;
	clc_out_t out_s2;
	logic     valid_s2;
	clc_out_t result;
	clc_cfg_t cfg;
	logic     advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	clc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clc_parse #(
		.NAME_COUNT_BITS    (NAME_COUNT_BITS),
		.CONTENT_COUNT_BITS (CONTENT_COUNT_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.word_in (word_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) word_s1 <= in_data;
		if (valid_s1 && advance) out_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule

// ===== src/clc_cfg.sv =====
// ----------------------------------------------------------------------------
// clc_cfg
// Limit registers written through the configuration channel.
// ----------------------------------------------------------------------------
module clc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [clc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output clc_pkg::clc_cfg_t                   cfg
);
	import clc_pkg::*;

	logic [NAME_LIMIT_W-1:0]    name_limit_q;
	logic [CONTENT_LIMIT_W-1:0] content_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q    <= NAME_LIMIT_RST;
			content_limit_q <= CONTENT_LIMIT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_NAME_LIMIT) begin
				name_limit_q <= cfg_data[NAME_LIMIT_W-1:0];
			end
			if (cfg_index == CFG_CONTENT_LIMIT) begin
				content_limit_q <= cfg_data[CONTENT_LIMIT_W-1:0];
			end
		end
	end

	assign cfg.name_limit    = name_limit_q;
	assign cfg.content_limit = content_limit_q;

endmodule

// ===== src/clc_parse.sv =====
// ----------------------------------------------------------------------------
// clc_parse
// Line grammar state and the one-byte step that tags a word and gives the
// verdict on the last byte of a line.
// ----------------------------------------------------------------------------
module clc_parse #(
	parameter int NAME_COUNT_BITS    = 6,
	parameter int CONTENT_COUNT_BITS = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  clc_pkg::clc_in_t  word_in,
	input  clc_pkg::clc_cfg_t cfg,
	output clc_pkg::clc_out_t result
);
	import clc_pkg::*;

	localparam int NW = (NAME_COUNT_BITS > NAME_LIMIT_W) ? NAME_COUNT_BITS : NAME_LIMIT_W;
	localparam int CW = (CONTENT_COUNT_BITS > CONTENT_LIMIT_W) ?
		CONTENT_COUNT_BITS : CONTENT_LIMIT_W;
	localparam logic [NW-1:0] NAME_TOP    = NW'((64'd1 << NAME_COUNT_BITS) - 64'd1);
	localparam logic [CW-1:0] CONTENT_TOP = CW'((64'd1 << CONTENT_COUNT_BITS) - 64'd1);

	phase_t                        phase_q, phase_d;
	logic [POS_W-1:0]              pos_q, pos_d;
	logic [NAME_COUNT_BITS-1:0]    ncnt_q, ncnt_d;
	logic [CONTENT_COUNT_BITS-1:0] ccnt_q, ccnt_d;
	kind_t                         kind_q, kind_d;
	logic                          ok_q, ok_d;

	logic [NW-1:0] name_cap;
	logic [CW-1:0] content_cap;
	logic [7:0]    b;
	tag_t          tag;
	kind_t         verdict;
	logic          verdict_ok;

	assign b = word_in.data_byte;
	assign name_cap = (NW'(cfg.name_limit) < NAME_TOP) ? NW'(cfg.name_limit) : NAME_TOP;
	assign content_cap = (CW'(cfg.content_limit) < CONTENT_TOP) ?
		CW'(cfg.content_limit) : CONTENT_TOP;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		ncnt_d     = ncnt_q;
		ccnt_d     = ccnt_q;
		kind_d     = kind_q;
		ok_d       = ok_q;
		tag        = TAG_NONE;
		verdict    = KIND_MSG;
		verdict_ok = 1'b0;

		unique case (phase_q)
			PH_START: begin
				phase_d = PH_LIT;
				pos_d   = 4'd1;
				priority if (b == "M") kind_d = KIND_MSG;
				else if (b == "E") kind_d = KIND_ERR;
				else if (b == "R") kind_d = KIND_REPLY;
				else if (b == "B") kind_d = KIND_BYE;
				else begin
					phase_d = PH_DEAD;
					pos_d   = pos_q;
				end
			end
			PH_LIT: begin
				if (kind_q == KIND_UNKNOWN || pos_q >= lead_len(kind_q) ||
					b != lead_char(kind_q, pos_q)) begin
					phase_d = PH_DEAD;
				end else begin
					pos_d = pos_q + 4'd1;
					if (pos_d == lead_len(kind_q)) begin
						pos_d = '0;
						priority if (kind_q == KIND_REPLY) phase_d = PH_WORD;
						else if (kind_q == KIND_BYE) phase_d = PH_DONE;
						else begin
							phase_d = PH_NAME;
							ncnt_d  = '0;
						end
					end
				end
			end
			PH_NAME: begin
				priority if (is_name_char(b) && NW'(ncnt_q) < name_cap) begin
					ncnt_d = ncnt_q + 1'b1;
					tag    = TAG_NAME;
				end else if (b == " " && ncnt_q != '0) begin
					phase_d = PH_IS;
					pos_d   = 4'd1;
				end else begin
					phase_d = PH_DEAD;
				end
			end
			PH_WORD: begin
				if (pos_q == '0) begin
					priority if (b == "O" || b == "N") begin
						ok_d  = (b == "O");
						pos_d = 4'd1;
						tag   = TAG_WORD;
					end else begin
						phase_d = PH_DEAD;
					end
				end else if (pos_q >= (ok_q ? 4'd2 : 4'd3) || b != word_char(ok_q, pos_q)) begin
					phase_d = PH_DEAD;
				end else begin
					tag   = TAG_WORD;
					pos_d = pos_q + 4'd1;
					if (pos_d == (ok_q ? 4'd2 : 4'd3)) begin
						phase_d = PH_IS;
						pos_d   = '0;
					end
				end
			end
			PH_IS: begin
				if (pos_q >= 4'd4 || b != is_char(pos_q)) begin
					phase_d = PH_DEAD;
				end else begin
					pos_d = pos_q + 4'd1;
					if (pos_d == 4'd4) begin
						phase_d = PH_CONTENT;
						pos_d   = '0;
						ccnt_d  = '0;
					end
				end
			end
			PH_CONTENT: begin
				priority if (b >= 8'h20 && b <= 8'h7E && CW'(ccnt_q) < content_cap) begin
					ccnt_d = ccnt_q + 1'b1;
					tag    = TAG_CONTENT;
				end else if (b == CH_CR && ccnt_q != '0) begin
					phase_d = PH_LF;
				end else begin
					phase_d = PH_DEAD;
				end
			end
			PH_LF: begin
				phase_d = (b == CH_LF) ? PH_DONE : PH_DEAD;
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase

		if (word_in.end_of_line) begin
			if (phase_d == PH_DONE && kind_d != KIND_UNKNOWN) begin
				verdict    = kind_d;
				verdict_ok = (kind_d == KIND_REPLY) && ok_d;
			end else begin
				verdict = KIND_UNKNOWN;
			end
			phase_d = PH_START;
			pos_d   = '0;
			ncnt_d  = '0;
			ccnt_d  = '0;
			kind_d  = KIND_UNKNOWN;
			ok_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q   <= '0;
			ncnt_q  <= '0;
			ccnt_q  <= '0;
			kind_q  <= KIND_UNKNOWN;
			ok_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			ncnt_q  <= ncnt_d;
			ccnt_q  <= ccnt_d;
			kind_q  <= kind_d;
			ok_q    <= ok_d;
		end
	end

	assign result.field_tag    = tag;
	assign result.line_done    = word_in.end_of_line;
	assign result.message_kind = verdict;
	assign result.reply_ok     = verdict_ok;

endmodule

// ===== dv/chat_line_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// chat_line_classifier_tb
// Byte-level testbench for the chat line classifier. Lines are fed one byte
// per word, each result word is checked field by field against a cycle-free
// parser that runs alongside, and the limit registers are swept between phases.
// ----------------------------------------------------------------------------
module chat_line_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import clc_pkg::*;

	localparam int NAME_BITS     = 6;
	localparam int TEXT_BITS     = 11;
	localparam int NAME_TOP      = (1 << NAME_BITS) - 1;
	localparam int TEXT_TOP      = (1 << TEXT_BITS) - 1;
	localparam int HOLD_CYCLES   = 150;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_BYTES  = 350;
	localparam int TAIL_BYTES    = 150;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef logic [7:0] line_t[$];

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	clc_in_t                in_data;
	logic                   out_valid;
	logic                   out_ready;
	clc_out_t               out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	chat_line_classifier #(
		.NAME_COUNT_BITS   (NAME_BITS),
		.CONTENT_COUNT_BITS(TEXT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	clc_out_t expected_verdicts[$];
	int       mismatch_count = 0;
	int       bytes_accepted = 0;
	bit       idling_enabled = 1'b1;
	bit       hold_req       = 1'b0;

	phase_t                  parse_ph;
	int                      lit_pos;
	int                      name_cnt;
	int                      text_cnt;
	kind_t                   line_kind;
	logic                    word_ok;
	logic [NAME_LIMIT_W-1:0]    name_max;
	logic [CONTENT_LIMIT_W-1:0] text_max;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------- line parser ----------------

	function automatic void restart_parser();
		parse_ph  = PH_START;
		lit_pos   = 0;
		name_cnt  = 0;
		text_cnt  = 0;
		line_kind = KIND_UNKNOWN;
		word_ok   = 1'b0;
	endfunction

	function automatic int opener_len(input kind_t k);
		case (k)
			KIND_MSG, KIND_ERR: return 9;
			KIND_REPLY:         return 6;
			default:            return 5;
		endcase
	endfunction

	function automatic logic [7:0] opener_char(input kind_t k, input int pos);
		string s;
		case (k)
			KIND_MSG:   s = "MSG FROM ";
			KIND_ERR:   s = "ERR FROM ";
			KIND_REPLY: s = "REPLY ";
			default:    s = "BYE";
		endcase
		if (k == KIND_BYE && pos == 3) return CH_CR;
		if (k == KIND_BYE && pos == 4) return CH_LF;
		return s[pos];
	endfunction

	function automatic bit name_char_ok(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || b == "-";
	endfunction

	function automatic clc_out_t classify_byte(input clc_in_t w);
		logic [7:0] b;
		tag_t       tag;
		clc_out_t   r;
		string      word;
		string      sep;
		int         wl;
		int         name_cap;
		int         text_cap;
		b        = w.data_byte;
		tag      = TAG_NONE;
		sep      = " IS ";
		name_cap = (name_max < NAME_TOP) ? name_max : NAME_TOP;
		text_cap = (text_max < TEXT_TOP) ? text_max : TEXT_TOP;
		case (parse_ph)
			PH_START: begin
				parse_ph = PH_LIT;
				lit_pos  = 1;
				case (b)
					"M":     line_kind = KIND_MSG;
					"E":     line_kind = KIND_ERR;
					"R":     line_kind = KIND_REPLY;
					"B":     line_kind = KIND_BYE;
					default: parse_ph = PH_DEAD;
				endcase
			end
			PH_LIT: begin
				if (line_kind == KIND_UNKNOWN || lit_pos >= opener_len(line_kind) ||
					b != opener_char(line_kind, lit_pos)) begin
					parse_ph = PH_DEAD;
				end else begin
					lit_pos++;
					if (lit_pos == opener_len(line_kind)) begin
						lit_pos = 0;
						case (line_kind)
							KIND_REPLY: parse_ph = PH_WORD;
							KIND_BYE:   parse_ph = PH_DONE;
							default: begin
								parse_ph = PH_NAME;
								name_cnt = 0;
							end
						endcase
					end
				end
			end
			PH_NAME: begin
				if (name_char_ok(b) && name_cnt < name_cap) begin
					name_cnt++;
					tag = TAG_NAME;
				end else if (b == " " && name_cnt >= 1) begin
					parse_ph = PH_IS;
					lit_pos  = 1;
				end else begin
					parse_ph = PH_DEAD;
				end
			end
			PH_WORD: begin
				if (lit_pos == 0) begin
					if (b == "O" || b == "N") begin
						word_ok = (b == "O");
						lit_pos = 1;
						tag     = TAG_WORD;
					end else begin
						parse_ph = PH_DEAD;
					end
				end else begin
					if (word_ok) begin
						word = "OK";
						wl   = 2;
					end else begin
						word = "NOK";
						wl   = 3;
					end
					if (lit_pos >= wl || b != word[lit_pos]) begin
						parse_ph = PH_DEAD;
					end else begin
						tag = TAG_WORD;
						lit_pos++;
						if (lit_pos == wl) begin
							parse_ph = PH_IS;
							lit_pos  = 0;
						end
					end
				end
			end
			PH_IS: begin
				if (lit_pos >= 4 || b != sep[lit_pos]) begin
					parse_ph = PH_DEAD;
				end else begin
					lit_pos++;
					if (lit_pos == 4) begin
						parse_ph = PH_CONTENT;
						lit_pos  = 0;
						text_cnt = 0;
					end
				end
			end
			PH_CONTENT: begin
				if (b >= 8'h20 && b <= 8'h7E && text_cnt < text_cap) begin
					text_cnt++;
					tag = TAG_CONTENT;
				end else if (b == CH_CR && text_cnt >= 1) begin
					parse_ph = PH_LF;
				end else begin
					parse_ph = PH_DEAD;
				end
			end
			PH_LF:   parse_ph = (b == CH_LF) ? PH_DONE : PH_DEAD;
			default: parse_ph = PH_DEAD;
		endcase
		r.field_tag    = tag;
		r.line_done    = w.end_of_line;
		r.message_kind = '0;
		r.reply_ok     = 1'b0;
		if (w.end_of_line) begin
			if (parse_ph == PH_DONE && line_kind != KIND_UNKNOWN) begin
				r.message_kind = line_kind;
				r.reply_ok     = (line_kind == KIND_REPLY) ? word_ok : 1'b0;
			end else begin
				r.message_kind = KIND_UNKNOWN;
			end
			restart_parser();
		end
		return r;
	endfunction

	// ---------------- line builders ----------------

	function automatic void put_text(ref line_t q, input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	function automatic line_t text_line(input string s, input bit crlf);
		line_t q;
		q = {};
		put_text(q, s);
		if (crlf) begin
			q.push_back(CH_CR);
			q.push_back(CH_LF);
		end
		return q;
	endfunction

	function automatic logic [7:0] random_name_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26) return 8'("A" + r);
		if (r < 52) return 8'("a" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return "-";
	endfunction

	function automatic line_t well_formed(input kind_t k, input int nlen, input int tlen,
		input logic ok);
		line_t q;
		q = {};
		case (k)
			KIND_BYE: put_text(q, "BYE");
			KIND_REPLY: begin
				put_text(q, "REPLY ");
				if (ok) put_text(q, "OK");
				else put_text(q, "NOK");
			end
			default: begin
				if (k == KIND_MSG) put_text(q, "MSG FROM ");
				else put_text(q, "ERR FROM ");
				repeat (nlen) q.push_back(random_name_char());
			end
		endcase
		if (k != KIND_BYE) begin
			put_text(q, " IS ");
			repeat (tlen) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end
		q.push_back(CH_CR);
		q.push_back(CH_LF);
		return q;
	endfunction

	function automatic line_t random_line();
		line_t q;
		string leads;
		int    r;
		int    n;
		int    nmax;
		int    tmax;
		int    nlen;
		int    tlen;
		leads = "MERB";
		q = {};
		if ($urandom_range(0, 9) < 3) begin
			n = $urandom_range(1, 12);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) q[0] = leads[$urandom_range(0, 3)];
			return q;
		end
		nmax = (name_max == 0) ? 1 : name_max;
		tmax = (text_max == 0) ? 1 : text_max;
		r = $urandom_range(0, 9);
		if (r == 0) nlen = nmax + 1;
		else if (r == 1) nlen = nmax;
		else if (r == 2) nlen = 0;
		else nlen = $urandom_range(1, (nmax < 10) ? nmax : 10);
		r = $urandom_range(0, 9);
		if (r == 0 && tmax <= 40) tlen = tmax + 1;
		else if (r == 1 && tmax <= 40) tlen = tmax;
		else if (r == 2) tlen = 0;
		else tlen = $urandom_range(1, (tmax < 24) ? tmax : 24);
		q = well_formed(kind_t'($urandom_range(0, 3)), nlen, tlen, $urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 3))
				0: q[n] = 8'($urandom_range(0, 255));
				1: q = q[0:n];
				2: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
				default: if (q.size() > 1) q.delete(n);
			endcase
		end
		return q;
	endfunction

	// ---------------- channel drivers ----------------

	task automatic send_word(input clc_in_t w);
		int gap;
		if (idling_enabled && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_verdicts.push_back(classify_byte(w));
		bytes_accepted++;
	endtask

	task automatic send_line(input line_t q);
		clc_in_t w;
		foreach (q[i]) begin
			w.data_byte   = q[i];
			w.end_of_line = (i == q.size() - 1);
			send_word(w);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_NAME_LIMIT) name_max = NAME_LIMIT_W'(val);
		else if (idx == CFG_CONTENT_LIMIT) text_max = CONTENT_LIMIT_W'(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_limits();
		case ($urandom_range(0, 4))
			0:       write_reg(CFG_NAME_LIMIT, 1);
			1:       write_reg(CFG_NAME_LIMIT, NAME_TOP);
			2:       write_reg(CFG_NAME_LIMIT, $urandom_range(1, NAME_TOP));
			default: write_reg(CFG_NAME_LIMIT, $urandom_range(2, 12));
		endcase
		case ($urandom_range(0, 4))
			0:       write_reg(CFG_CONTENT_LIMIT, 1);
			1:       write_reg(CFG_CONTENT_LIMIT, TEXT_TOP);
			2:       write_reg(CFG_CONTENT_LIMIT, CONTENT_LIMIT_RST);
			default: write_reg(CFG_CONTENT_LIMIT, $urandom_range(1, 30));
		endcase
	endtask

	// ---------------- tests ----------------

	task automatic test_directed_lines();
		line_t q;
		send_line(text_line("BYE", 1));
		send_line(text_line("MSG FROM AZaz09- IS hello ~", 1));
		send_line(text_line("ERR FROM x IS  !", 1));
		send_line(text_line("REPLY OK IS ok", 1));
		send_line(text_line("REPLY NOK IS no", 1));
		send_line(text_line("REPLY NO IS x", 1));
		send_line(text_line("MSG FROM  IS x", 1));
		send_line(text_line("REPLY OK IS ", 1));
		send_line(text_line("MSG FROM a/ IS x", 1));
		q = text_line("BYE", 1);
		q.push_back("X");
		send_line(q);
		send_line(text_line("BYE", 0));
		q = text_line("MSG FROM a IS x", 0);
		q.push_back(8'h7F);
		q.push_back(CH_CR);
		q.push_back(CH_LF);
		send_line(q);
		q = text_line("MSG FROM a IS x", 0);
		q.push_back(CH_LF);
		send_line(q);
		q = {8'hFF};
		send_line(q);
		q = {8'h00};
		send_line(q);
	endtask

	task automatic test_limit_edges();
		write_reg(CFG_NAME_LIMIT, 1);
		write_reg(CFG_CONTENT_LIMIT, 1);
		send_line(well_formed(KIND_MSG, 1, 1, 1'b0));
		send_line(well_formed(KIND_MSG, 2, 1, 1'b0));
		send_line(well_formed(KIND_ERR, 1, 2, 1'b0));
		send_line(well_formed(KIND_REPLY, 0, 1, 1'b1));
		write_reg(CFG_NAME_LIMIT, NAME_TOP);
		write_reg(CFG_CONTENT_LIMIT, TEXT_TOP);
		send_line(well_formed(KIND_ERR, NAME_TOP, 3, 1'b0));
		send_line(well_formed(KIND_MSG, NAME_TOP + 1, 3, 1'b0));
		write_reg(CFG_NAME_LIMIT, 0);
		send_line(well_formed(KIND_MSG, 1, 2, 1'b0));
		send_line(well_formed(KIND_REPLY, 0, 2, 1'b0));
		write_reg(CFG_CONTENT_LIMIT, 0);
		send_line(well_formed(KIND_REPLY, 0, 1, 1'b1));
		send_line(well_formed(KIND_BYE, 0, 0, 1'b0));
		// upper data bits must be dropped for the name limit
		write_reg(CFG_NAME_LIMIT, 11'h7C3);
		write_reg(CFG_CONTENT_LIMIT, 5);
		send_line(well_formed(KIND_MSG, 3, 5, 1'b0));
		send_line(well_formed(KIND_MSG, 4, 5, 1'b0));
		send_line(well_formed(KIND_ERR, 3, 6, 1'b0));
		write_reg(CFG_SPARE_A, $urandom_range(0, TEXT_TOP));
		write_reg(CFG_SPARE_B, $urandom_range(0, TEXT_TOP));
		send_line(well_formed(KIND_ERR, 3, 5, 1'b0));
		write_reg(CFG_NAME_LIMIT, NAME_LIMIT_RST);
		write_reg(CFG_CONTENT_LIMIT, CONTENT_LIMIT_RST);
	endtask

	task automatic test_output_stall();
		hold_req = 1'b1;
		repeat (4) send_line(well_formed(KIND_MSG, 5, 20, 1'b0));
		wait (hold_req == 1'b0);
	endtask

	task automatic test_random_traffic(input int budget, input bit allow_idle);
		int stop_at;
		int lines_left;
		stop_at = bytes_accepted + budget;
		while (bytes_accepted < stop_at) begin
			pick_limits();
			idling_enabled = allow_idle && ($urandom_range(0, 3) != 0);
			lines_left = $urandom_range(4, 8);
			while (lines_left > 0 && bytes_accepted < stop_at) begin
				send_line(random_line());
				lines_left--;
			end
		end
	endtask

	// ---------------- result side ----------------

	initial begin : receiver
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		clc_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("result word with nothing pending: %h", out_data);
				mismatch_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (out_data.field_tag !== want.field_tag) begin
					$error("field_tag: expected %0d, got %0d", want.field_tag,
						out_data.field_tag);
					mismatch_count++;
				end
				if (out_data.line_done !== want.line_done) begin
					$error("line_done: expected %0d, got %0d", want.line_done,
						out_data.line_done);
					mismatch_count++;
				end
				if (out_data.message_kind !== want.message_kind) begin
					$error("message_kind: expected %0d, got %0d", want.message_kind,
						out_data.message_kind);
					mismatch_count++;
				end
				if (out_data.reply_ok !== want.reply_ok) begin
					$error("reply_ok: expected %0d, got %0d", want.reply_ok,
						out_data.reply_ok);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL");
		$finish;
	end

	// ---------------- sequence ----------------

	initial begin : main
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		name_max  = NAME_LIMIT_RST;
		text_max  = CONTENT_LIMIT_RST;
		restart_parser();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_lines();
		test_limit_edges();
		test_output_stall();
		test_random_traffic(RANDOM_BYTES, 1'b1);
		idling_enabled = 1'b0;
		test_random_traffic(TAIL_BYTES, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== chat_line_classifier.f =====
src/clc_pkg.sv
src/clc_cfg.sv
src/clc_parse.sv
src/chat_line_classifier.sv
dv/chat_line_classifier_tb.sv
